>>> rtl/irt_pkg.sv
// Shared types, widths and helpers for the radix text formatter.
// Used by irt_div, irt_dbuf and integer_to_radix_text_unit; no dependencies.
`timescale 1ns / 1ps

package irt_pkg;

  localparam int VAL_W      = 64;
  localparam int RADIX_W    = 5;
  localparam int LEN_W      = 7;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int MAX_DIGITS = 64;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int STEP_W     = $clog2(VAL_W);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAD,
    ST_LOAD,
    ST_DIVIDE,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Upper-case digit symbol for a value 0..15.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_W'("0") + CHAR_W'(d);
    end else begin
      c = CHAR_W'("A") + CHAR_W'(d) - CHAR_W'(10);
    end
    return c;
  endfunction

endpackage

>>> rtl/integer_to_radix_text_unit.sv
// Converts an unsigned 64-bit value to text in radix 2..16 and streams it out
// one character per item: pad bytes up to min_length (capped at 64), then
// digits most significant first in 0-9/A-F, with last on the final character.
// A radix outside 2..16 gives a single item with bad_radix and last set and
// text_char 0. One input item is handled at a time; in_ready is high only
// when idle. Each digit takes one pass of the shared bit-serial divider
// (a load, 64 shift/subtract steps, then the remainder is stored), and each
// output character goes through the registered digit buffer (a fetch, then
// an emit), so an item's time grows with its digits and characters, plus any
// output stall. Depends on irt_pkg, irt_div and irt_dbuf.
`timescale 1ns / 1ps

module integer_to_radix_text_unit
  import irt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VAL_W-1:0]   value,
  input  logic [RADIX_W-1:0] radix,
  input  logic [LEN_W-1:0]   min_length,
  input  logic [CHAR_W-1:0]  pad_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  text_char,
  output logic               last,
  output logic               bad_radix
);

  state_t             state, state_next;
  logic [VAL_W-1:0]   num, num_next;
  logic [RADIX_W-1:0] radix_r, radix_r_next;
  logic [CNT_W-1:0]   minlen, minlen_next;
  logic [CHAR_W-1:0]  pad, pad_next;
  logic [CNT_W-1:0]   ndig, ndig_next;
  logic [CNT_W-1:0]   total, total_next;
  logic [CNT_W-1:0]   k, k_next;
  logic               out_valid_next;
  logic [CHAR_W-1:0]  text_char_next;
  logic               last_next;
  logic               bad_radix_next;

  div_req_t           div_req;
  div_stat_t          div_stat;
  logic [VAL_W-1:0]   div_quot;
  logic [DIGIT_W-1:0] div_rem;

  logic               wr_en;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [DIGIT_W-1:0] rd_data;

  logic               slot_free;
  logic [CNT_W-1:0]   ndig_inc;
  logic [CNT_W-1:0]   npad;
  logic               at_end;

  irt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (num),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  irt_dbuf u_dbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ndig[IDX_W-1:0]),
    .wr_data (div_rem),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      ndig      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      ndig      <= ndig_next;
    end
  end

  always_ff @(posedge clk) begin
    num       <= num_next;
    radix_r   <= radix_r_next;
    minlen    <= minlen_next;
    pad       <= pad_next;
    total     <= total_next;
    k         <= k_next;
    text_char <= text_char_next;
    last      <= last_next;
    bad_radix <= bad_radix_next;
  end

  always_comb begin
    slot_free = !out_valid || out_ready;
    ndig_inc  = ndig + CNT_W'(1);
    npad      = total - ndig;
    at_end    = (k == total - CNT_W'(1));
    // Digits sit least significant first, so character k reads from the top.
    rd_addr   = IDX_W'(total - CNT_W'(1) - k);

    state_next      = state;
    num_next        = num;
    radix_r_next    = radix_r;
    minlen_next     = minlen;
    pad_next        = pad;
    ndig_next       = ndig;
    total_next      = total;
    k_next          = k;
    out_valid_next  = out_valid && !out_ready;
    text_char_next  = text_char;
    last_next       = last;
    bad_radix_next  = bad_radix;
    div_req.start   = 1'b0;
    div_req.divisor = radix_r;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    in_ready        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          num_next     = value;
          radix_r_next = radix;
          pad_next     = pad_char;
          ndig_next    = '0;
          if (min_length > LEN_W'(MAX_DIGITS)) begin
            minlen_next = CNT_W'(MAX_DIGITS);
          end else begin
            minlen_next = CNT_W'(min_length);
          end
          if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            state_next = ST_BAD;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_BAD: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          text_char_next = '0;
          last_next      = 1'b1;
          bad_radix_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_LOAD: begin
        div_req.start = 1'b1;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          wr_en     = 1'b1;
          ndig_next = ndig_inc;
          num_next  = div_quot;
          if (div_quot == '0 || ndig_inc == CNT_W'(MAX_DIGITS)) begin
            total_next = (ndig_inc > minlen) ? ndig_inc : minlen;
            k_next     = '0;
            state_next = ST_FETCH;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_FETCH: begin
        rd_en      = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          text_char_next = (k < npad) ? pad : digit_char(rd_data);
          last_next      = at_end;
          bad_radix_next = 1'b0;
          if (at_end) begin
            state_next = ST_IDLE;
          end else begin
            k_next     = k + CNT_W'(1);
            state_next = ST_FETCH;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide phase");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_radix |-> last)
    else $error("bad radix item not flagged last");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != ST_IDLE)
    else $error("accepted item did not start work");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    ndig <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond buffer depth");
`endif

endmodule

>>> rtl/irt_div.sv
// Bit-serial restoring divider: 64-bit dividend by a 5-bit radix, one
// quotient bit per cycle. Depends on irt_pkg.
`timescale 1ns / 1ps

module irt_div
  import irt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  div_req_t           req,
  input  logic [VAL_W-1:0]   dividend,
  output div_stat_t          stat,
  output logic [VAL_W-1:0]   quot,
  output logic [DIGIT_W-1:0] rem
);

  logic [VAL_W-1:0]   dvd;
  logic [DIGIT_W-1:0] rem_r;
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic               done;

  logic [DIGIT_W:0]   rem_sh;
  logic               fits;
  logic [DIGIT_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, dvd[VAL_W-1]};
    fits    = (rem_sh >= req.divisor);
    rem_sub = rem_sh - req.divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (step == STEP_W'(VAL_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd   <= dividend;
      rem_r <= '0;
      step  <= '0;
    end else if (busy) begin
      // Shift in the next dividend bit, subtract the radix when it fits.
      dvd   <= {dvd[VAL_W-2:0], fits};
      rem_r <= fits ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
      step  <= step + STEP_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = dvd;
  assign rem       = rem_r;

endmodule

>>> rtl/irt_dbuf.sv
// Digit buffer: one write port, one registered read port, digit values 0..15.
// Depends on irt_pkg.
`timescale 1ns / 1ps

module irt_dbuf
  import irt_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [DIGIT_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [DIGIT_W-1:0] rd_data
);

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
